// ----- rtl/core/sm3_hash_engine_unit_macros.svh -----
// Assertion macros for the SM3 hash engine.
// Used by sm3_hash_engine_unit; depends on nothing else.
`ifndef SM3_HASH_ENGINE_UNIT_MACROS_SVH
`define SM3_HASH_ENGINE_UNIT_MACROS_SVH

// Implication checked every clock edge, disabled during reset.
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sm3_pkg.sv -----
// Shared constants and functions for the SM3 hash engine.
// No dependencies.
package sm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds     = 64;
   localparam logic [7:0]  PadByte    = 8'h80;
   localparam logic [6:0]  LenOffset  = 7'd56;
   localparam logic [31:0] TjLow      = 32'h79CC4519;
   localparam logic [31:0] TjHigh     = 32'h7A879D8A;

   localparam logic [255:0] InitValue = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

   // Rotate left by n bits (0..31).
   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ----- rtl/core/sm3_hash_engine_unit.sv -----
// SM3 hash engine: byte packing, padding, iterative compression, digest out.
// Depends on sm3_pkg and sm3_hash_engine_unit_macros.svh.
//
// Usage: the req channel carries message words (req_data_word, first byte in
// bits 31..24), req_byte_count (0..4, larger counts act as 4) and req_last.
// A transaction is accepted when req_valid is high and req_stall is low.
// Each accepted byte is placed into the 64-byte block, one byte per cycle
// while no compression runs. When the block fills, one shared round unit
// runs the 64 SM3 rounds, one round per cycle, then folds the result into
// the chaining value. On req_last the block appends padding byte by byte
// and runs one or two more compressions, then emits four rsp transactions
// of 64 bits each (rsp_part_index 0 first, rsp_last_part on the fourth).
// The rsp outputs hold while rsp_stall is high; req is not taken until all
// four parts are delivered. Synchronous reset returns the block to idle with
// the SM3 initial value loaded and the length count cleared.
module sm3_hash_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part,
   output logic [1:0]  rsp_part_index,
   output logic        rsp_last_part
);
`include "sm3_hash_engine_unit_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE, ST_BYTES, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT
   } state_type;

   state_type      state_ff, state_in;
   logic [31:0]    word_ff, word_in;
   logic [2:0]     left_ff, left_in;
   logic           last_ff, last_in;
   logic           padded_ff, padded_in;   // 0x80 byte already placed
   logic           final_ff, final_in;     // current compression is the last one
   logic [5:0]     fill_ff, fill_in;
   logic [63:0]    bits_ff, bits_in;
   logic [255:0]   cv_ff, cv_in;
   logic [255:0]   work_ff, work_in;
   logic [31:0]    buf_ff [16];
   logic [31:0]    win_ff [16];
   logic [5:0]     round_ff, round_in;
   logic [1:0]     part_ff, part_in;

   // Byte writer inputs.
   logic           put_en;
   logic [7:0]     put_byte;
   logic           load_win;
   logic           shift_win;
   logic           len_write;

   // Round datapath.
   logic [31:0] a, b, c, d, e, f, g, h, wj, wp, tj, ss1, ss2, ff_v, gg_v, tt1, tt2, nw;
   always_comb begin
      a = work_ff[255:224]; b = work_ff[223:192]; c = work_ff[191:160];
      d = work_ff[159:128]; e = work_ff[127:96];  f = work_ff[95:64];
      g = work_ff[63:32];   h = work_ff[31:0];
      wj = win_ff[0];
      wp = wj ^ win_ff[4];
      tj = (round_ff < 6'd16) ? sm3_pkg::TjLow : sm3_pkg::TjHigh;
      ss1 = sm3_pkg::rotl(sm3_pkg::rotl(a, 5'd12) + e + sm3_pkg::rotl(tj, round_ff[4:0]),
                          5'd7);
      ss2 = ss1 ^ sm3_pkg::rotl(a, 5'd12);
      ff_v = (round_ff < 6'd16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
      gg_v = (round_ff < 6'd16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
      tt1 = ff_v + d + ss2 + wp;
      tt2 = gg_v + h + ss1 + wj;
      nw = sm3_pkg::perm1(win_ff[0] ^ win_ff[7] ^ sm3_pkg::rotl(win_ff[13], 5'd15))
           ^ sm3_pkg::rotl(win_ff[3], 5'd7) ^ win_ff[10];
   end

   // Sequencer next state.
   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      left_in   = left_ff;
      last_in   = last_ff;
      padded_in = padded_ff;
      final_in  = final_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      cv_in     = cv_ff;
      work_in   = work_ff;
      round_in  = round_ff;
      part_in   = part_ff;
      put_en    = 1'b0;
      put_byte  = 8'h00;
      load_win  = 1'b0;
      shift_win = 1'b0;
      len_write = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in   = req_data_word;
               left_in   = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
               last_in   = req_last;
               padded_in = 1'b0;
               state_in  = ST_BYTES;
            end
         end
         ST_BYTES: begin
            if (left_ff != 3'd0) begin
               put_en   = 1'b1;
               put_byte = word_ff[31:24];
               word_in  = {word_ff[23:0], 8'h00};
               left_in  = left_ff - 3'd1;
               bits_in  = bits_ff + 64'd8;
               fill_in  = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  load_win = 1'b1;
                  work_in  = cv_ff;
                  round_in = 6'd0;
                  final_in = 1'b0;
                  state_in = ST_ROUND;
               end
            end else begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            put_en   = 1'b1;
            put_byte = padded_ff ? 8'h00 : sm3_pkg::PadByte;
            padded_in = 1'b1;
            fill_in  = fill_ff + 6'd1;
            if (padded_ff && {1'b0, fill_ff} == sm3_pkg::LenOffset) begin
               // Length slot reached in this block: write length and compress.
               put_en    = 1'b0;
               fill_in   = 6'd0;
               len_write = 1'b1;
               final_in  = 1'b1;
               state_in  = ST_ROUND;
            end else if (fill_ff == 6'd63) begin
               load_win = 1'b1;
               work_in  = cv_ff;
               round_in = 6'd0;
               final_in = 1'b0;
               state_in = ST_ROUND;
            end
            if (len_write) begin
               work_in  = cv_ff;
               round_in = 6'd0;
            end
         end
         ST_ROUND: begin
            shift_win = 1'b1;
            work_in = {tt1, a, sm3_pkg::rotl(b, 5'd9), c,
                       sm3_pkg::perm0(tt2), e, sm3_pkg::rotl(f, 5'd19), g};
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cv_in = cv_ff ^ work_ff;
            if (final_ff) begin
               work_in  = cv_ff ^ work_ff;
               part_in  = 2'd0;
               state_in = ST_OUT;
            end else begin
               state_in = (left_ff != 3'd0) ? ST_BYTES : (last_ff ? ST_PAD : ST_IDLE);
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  cv_in    = sm3_pkg::InitValue;
                  bits_in  = 64'd0;
                  fill_in  = 6'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= 6'd0;
         bits_ff   <= 64'd0;
         cv_ff     <= sm3_pkg::InitValue;
         round_ff  <= 6'd0;
         part_ff   <= 2'd0;
         left_ff   <= 3'd0;
         last_ff   <= 1'b0;
         padded_ff <= 1'b0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         cv_ff     <= cv_in;
         round_ff  <= round_in;
         part_ff   <= part_in;
         left_ff   <= left_in;
         last_ff   <= last_in;
         padded_ff <= padded_in;
         final_ff  <= final_in;
      end
      word_ff <= word_in;
      work_ff <= work_in;
   end

   // Block buffer writes: byte merge.
   always_ff @(posedge clock) begin
      if (put_en) begin
         case (fill_ff[1:0])
            2'd0:    buf_ff[fill_ff[5:2]] <= {put_byte, 24'h0};
            2'd1:    buf_ff[fill_ff[5:2]][23:16] <= put_byte;
            2'd2:    buf_ff[fill_ff[5:2]][15:8]  <= put_byte;
            default: buf_ff[fill_ff[5:2]][7:0]   <= put_byte;
         endcase
      end
   end

   // Expansion window: loaded from the buffer (or buffer plus length words), then slides one word per round.
   always_ff @(posedge clock) begin
      if (load_win) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= buf_ff[i];
         end
         // The final byte lands in word 15 this same cycle.
         win_ff[15] <= {buf_ff[15][31:8], put_byte};
      end else if (len_write) begin
         for (int i = 0; i < 14; i++) begin
            win_ff[i] <= buf_ff[i];
         end
         win_ff[14] <= bits_ff[63:32];
         win_ff[15] <= bits_ff[31:0];
      end else if (shift_win) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= nw;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_part_index  = part_ff;
   assign rsp_last_part   = (part_ff == 2'd3);
   always_comb begin
      case (part_ff)
         2'd0:    rsp_digest_part = work_ff[255:192];
         2'd1:    rsp_digest_part = work_ff[191:128];
         2'd2:    rsp_digest_part = work_ff[127:64];
         default: rsp_digest_part = work_ff[63:0];
      endcase
   end

   `SM3_ASSERT_IMPL(a_busy_no_rsp, clock, reset, rsp_valid, req_stall, "rsp while idle")
   `SM3_ASSERT_NEXT(a_round_end, clock, reset, state_ff == ST_ROUND && round_ff == 6'd63, state_ff == ST_FOLD, "round count slip")
   `SM3_ASSERT_NEXT(a_done_reset, clock, reset, rsp_valid && !rsp_stall && rsp_last_part, !rsp_valid && bits_ff == 64'd0, "no restart after digest")
endmodule
